// ===== design/qclt_pkg.sv =====
// ----------------------------------------------------------------------------
// qclt_pkg
// Shared types and character constants for the quoted command line tokenizer.
// ----------------------------------------------------------------------------
package qclt_pkg;

    localparam int CHAR_W      = 16;
    localparam int MAX_RESULTS = 3;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;

    typedef enum logic [1:0] {
        MODE_OUT    = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_SINGLE = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

endpackage

// ===== design/quoted_command_line_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// quoted_command_line_tokenizer_core
// Splits a command string into tokens, one 16-bit character per item.
// ----------------------------------------------------------------------------
// Usage: the sender offers one character per item on ch with end_of_string
// set on the final character, under item_valid / item_ready. The block
// returns result items on kind / ch_out / last under result_valid /
// result_ready: token characters (kind 0) and token-end marks (kind 1).
// last marks the final result caused by an input item; an input item may
// cause no result at all, or up to three.
// Path: an accepted item is held in the input register and decoded there
// combinationally; its results are loaded into the result buffer once it is free.
// Throughput: one item per cycle while each item causes at most one result
// and the receiver is ready; an item with several results holds the result
// buffer until each has been taken in turn through the single result port.
// While the receiver stalls, the result buffer holds and the input register
// fills, after which item_ready falls until the buffer drains.
// Reset clears the quote mode, escape and token flags and empties both
// registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quoted_command_line_tokenizer_core
    import qclt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [CHAR_W-1:0] ch,
    input  logic              end_of_string,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              kind,
    output logic [CHAR_W-1:0] ch_out,
    output logic              last
);

    // Input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic              eos_reg;

    // Tokenizer state
    mode_t mode_reg, mode_next;
    logic  esc_reg, esc_next;
    logic  tok_reg, tok_next;

    // Result buffer
    logic [RES_IDX_W-1:0] cnt_reg, cnt_next;
    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    kind_t                buf_kind_reg [MAX_RESULTS];
    logic [CHAR_W-1:0]    buf_ch_reg   [MAX_RESULTS];

    // Decoded results of the held item
    kind_t                dec_kind [MAX_RESULTS];
    logic [CHAR_W-1:0]    dec_ch   [MAX_RESULTS];
    logic [RES_IDX_W-1:0] dec_cnt;

    logic out_fire;
    logic out_done;
    logic buf_free;
    logic load;

    assign result_valid = (cnt_reg != '0);
    assign out_fire     = result_valid && result_ready;
    assign last         = (idx_reg == cnt_reg - RES_IDX_W'(1));
    assign out_done     = out_fire && last;
    assign buf_free     = !result_valid || out_done;
    assign load         = in_valid_reg && buf_free;
    assign item_ready   = !in_valid_reg || load;

    assign kind   = buf_kind_reg[idx_reg];
    assign ch_out = buf_ch_reg[idx_reg];

    // Per-character decision. Results are appended in order to a three-entry
    // list; tok_next follows each append as in the sequential rules.
    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        tok_next  = tok_reg;
        dec_cnt   = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            dec_kind[i] = KIND_CHAR;
            dec_ch[i]   = CH_NUL;
        end

        if (esc_reg)
        begin
            esc_next = 1'b0;
            // Inside quotes a backslash before an unescapable char is kept.
            if ((mode_reg == MODE_SINGLE && ch_reg != CH_SQUOTE) ||
                (mode_reg == MODE_DOUBLE && ch_reg != CH_DQUOTE &&
                 ch_reg != CH_BSLASH))
            begin
                dec_kind[dec_cnt] = KIND_CHAR;
                dec_ch[dec_cnt]   = CH_BSLASH;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
            end
            dec_kind[dec_cnt] = KIND_CHAR;
            dec_ch[dec_cnt]   = ch_reg;
            dec_cnt           = dec_cnt + RES_IDX_W'(1);
            tok_next          = 1'b1;
        end
        else if (ch_reg == CH_DQUOTE || ch_reg == CH_SQUOTE)
        begin
            if ((ch_reg == CH_DQUOTE && mode_reg == MODE_DOUBLE) ||
                (ch_reg == CH_SQUOTE && mode_reg == MODE_SINGLE))
            begin
                // A closing quote ends the token even when it is empty.
                mode_next         = MODE_OUT;
                dec_kind[dec_cnt] = KIND_END;
                dec_ch[dec_cnt]   = CH_NUL;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
                tok_next          = 1'b0;
            end
            else if (mode_reg == MODE_DOUBLE || mode_reg == MODE_SINGLE)
            begin
                dec_kind[dec_cnt] = KIND_CHAR;
                dec_ch[dec_cnt]   = ch_reg;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
                tok_next          = 1'b1;
            end
            else
            begin
                mode_next = (ch_reg == CH_DQUOTE) ? MODE_DOUBLE : MODE_SINGLE;
            end
        end
        else if (ch_reg == CH_BSLASH)
        begin
            if (eos_reg)
            begin
                dec_kind[dec_cnt] = KIND_CHAR;
                dec_ch[dec_cnt]   = CH_BSLASH;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
                tok_next          = 1'b1;
            end
            else
            begin
                esc_next = 1'b1;
            end
        end
        else if (ch_reg == CH_SPACE)
        begin
            if (mode_reg == MODE_DOUBLE || mode_reg == MODE_SINGLE)
            begin
                dec_kind[dec_cnt] = KIND_CHAR;
                dec_ch[dec_cnt]   = ch_reg;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
                tok_next          = 1'b1;
            end
            else if (tok_reg)
            begin
                dec_kind[dec_cnt] = KIND_END;
                dec_ch[dec_cnt]   = CH_NUL;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
                tok_next          = 1'b0;
            end
        end
        else
        begin
            dec_kind[dec_cnt] = KIND_CHAR;
            dec_ch[dec_cnt]   = ch_reg;
            dec_cnt           = dec_cnt + RES_IDX_W'(1);
            tok_next          = 1'b1;
        end

        // End of string flushes a nonempty token and drops any open quote.
        if (eos_reg)
        begin
            if (tok_next)
            begin
                dec_kind[dec_cnt] = KIND_END;
                dec_ch[dec_cnt]   = CH_NUL;
                dec_cnt           = dec_cnt + RES_IDX_W'(1);
            end
            mode_next = MODE_OUT;
            esc_next  = 1'b0;
            tok_next  = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = dec_cnt;
            idx_next = '0;
        end
        else if (out_done)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (out_fire)
        begin
            idx_next = idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_OUT;
            esc_reg      <= 1'b0;
            tok_reg      <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (load)
            begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                tok_reg  <= tok_next;
            end
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            ch_reg  <= ch;
            eos_reg <= end_of_string;
        end
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_kind_reg[i] <= dec_kind[i];
                buf_ch_reg[i]   <= dec_ch[i];
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the quoted command line tokenizer core. A driver feeds
// command strings one character per item and a monitor compares every
// result against a token predictor built from the tokenizer rules, with
// random idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
    import qclt_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] c;
        logic              eos;
        int unsigned       gap;
    } char_item_t;

    typedef struct {
        kind_t             kind;
        logic [CHAR_W-1:0] c;
        logic              last;
    } token_res_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    logic [CHAR_W-1:0] ch = '0;
    logic              end_of_string = 1'b0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              kind;
    logic [CHAR_W-1:0] ch_out;
    logic              last;

    char_item_t  pending_chars[$];
    token_res_t  expected_tokens[$];
    token_res_t  item_out[$];

    // Predictor state.
    mode_t       tok_mode = MODE_OUT;
    bit          esc_seen = 1'b0;
    bit          tok_open = 1'b0;

    bit          took_item = 1'b0;
    bit          took_result = 1'b0;
    bit          calm = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int unsigned results_checked = 0;
    int unsigned queued_count = 0;
    int unsigned error_count = 0;

    quoted_command_line_tokenizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .ch           (ch),
        .end_of_string(end_of_string),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .ch_out       (ch_out),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic void emit_char(logic [CHAR_W-1:0] c);
        item_out.push_back('{KIND_CHAR, c, 1'b0});
        tok_open = 1'b1;
    endfunction

    function automatic void emit_end();
        item_out.push_back('{KIND_END, CH_NUL, 1'b0});
        tok_open = 1'b0;
    endfunction

    // A quote closes its own span, is literal inside the other kind of span,
    // and otherwise opens a span without ending the current token.
    function automatic void quote_char(logic [CHAR_W-1:0] c, mode_t own, mode_t other);
        if (tok_mode == own)
        begin
            tok_mode = MODE_OUT;
            emit_end();
        end
        else if (tok_mode == other)
            emit_char(c);
        else
            tok_mode = own;
    endfunction

    function automatic void predict_tokens(logic [CHAR_W-1:0] c, logic eos);
        item_out.delete();
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (tok_mode == MODE_SINGLE)
            begin
                if (c != CH_SQUOTE)
                    emit_char(CH_BSLASH);
                emit_char(c);
            end
            else if (tok_mode == MODE_DOUBLE)
            begin
                if (c != CH_DQUOTE && c != CH_BSLASH)
                    emit_char(CH_BSLASH);
                emit_char(c);
            end
            else
                emit_char(c);
        end
        else if (c == CH_DQUOTE)
            quote_char(c, MODE_DOUBLE, MODE_SINGLE);
        else if (c == CH_SQUOTE)
            quote_char(c, MODE_SINGLE, MODE_DOUBLE);
        else if (c == CH_BSLASH)
        begin
            // A backslash at the end of the string stays literal.
            if (eos)
                emit_char(CH_BSLASH);
            else
                esc_seen = 1'b1;
        end
        else if (c == CH_SPACE)
        begin
            if (tok_mode == MODE_DOUBLE || tok_mode == MODE_SINGLE)
                emit_char(c);
            else if (tok_open)
                emit_end();
        end
        else
            emit_char(c);

        if (eos)
        begin
            if (tok_open)
                emit_end();
            tok_mode = MODE_OUT;
            esc_seen = 1'b0;
            tok_open = 1'b0;
        end

        if (item_out.size() > 0)
            item_out[item_out.size() - 1].last = 1'b1;
        foreach (item_out[i])
            expected_tokens.push_back(item_out[i]);
    endfunction

    task automatic push_item(logic [CHAR_W-1:0] c, logic eos);
        char_item_t it;
        it.c = c;
        it.eos = eos;
        it.gap = calm ? 0 : $urandom_range(0, 9);
        pending_chars.push_back(it);
        queued_count++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_item({8'h00, s[i]}, i == s.len() - 1);
    endtask

    // Weighted toward the characters that steer the tokenizer.
    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return CH_DQUOTE;
        else if (r < 24)
            return CH_SQUOTE;
        else if (r < 36)
            return CH_BSLASH;
        else if (r < 52)
            return CH_SPACE;
        else if (r < 56)
            return CH_NUL;
        else if (r < 60)
            return 16'hFFFF;
        else if (r < 80)
            return CHAR_W'(16'h0061 + $urandom_range(0, 25));
        else
            return CHAR_W'($urandom_range(0, 65535));
    endfunction

    // Input side: an item stays on the port until taken, then the next one
    // follows after its own idle gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && took_item)
                send_wait = (pending_chars.size() > 0) ? pending_chars[0].gap : 0;
            if (item_valid && !took_item)
            begin
                // Hold the current item.
            end
            else if (send_wait > 0)
            begin
                send_wait--;
                item_valid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                item_valid <= 1'b1;
                ch <= pending_chars[0].c;
                end_of_string <= pending_chars[0].eos;
                void'(pending_chars.pop_front());
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Output side: a random stall per result, a quiet window, and one long
    // hold-off that backs the block up into its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_result)
                recv_wait = (results_checked >= 250 && results_checked < 350) ?
                            0 : $urandom_range(0, 9);
            if (!hold_done && results_checked >= 60)
            begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        token_res_t want;
        took_item = rst_n && item_valid && item_ready;
        took_result = rst_n && result_valid && result_ready;
        if (took_item)
            predict_tokens(ch, end_of_string);
        if (took_result)
        begin
            results_checked++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: kind %0d ch_out 0x%04h last %0d",
                       kind, ch_out, last);
                error_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, got %0d", want.kind, kind);
                    error_count++;
                end
                if (ch_out !== want.c)
                begin
                    $error("ch_out mismatch: expected 0x%04h, got 0x%04h", want.c, ch_out);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int unsigned len;

        // Extreme code units around a space.
        push_item(CH_NUL, 1'b0);
        push_item(CH_SPACE, 1'b0);
        push_item(16'hFFFF, 1'b1);
        // An empty double-quoted span still ends a token.
        push_text("\"\"");
        // Quote opened inside a token, other quote literal, trailing backslash.
        push_text("a'b\"'\\");
        // Escapes inside a double span; the span is left open at the end.
        push_text("\"\\\"\\\\\\x");
        // Escaped plain character in a single span gives three results.
        push_text("'\\y");
        // Escaped space outside quotes, then trailing spaces.
        push_text("\\  ");

        while (queued_count < 224)
        begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++)
            begin
                calm = (queued_count >= 64 && queued_count < 114);
                push_item(pick_char(), j == len - 1);
            end
        end

        @(posedge rst_n);
        while (pending_chars.size() > 0 || item_valid)
            @(posedge clk);
        while (expected_tokens.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("quoted_command_line_tokenizer_core regression: pass");
        else
            $display("quoted_command_line_tokenizer_core regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("quoted_command_line_tokenizer_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qclt_pkg.sv
design/quoted_command_line_tokenizer_core.sv
tb/sv/tb_top.sv
